>>> rtl/core/sscal_pkg.sv
// ----------------------------------------------------------------------------
// sscal_pkg
// shared types and constants for the slab size class allocator
// ----------------------------------------------------------------------------
package sscal_pkg;

  localparam int DEF_PAGE_BYTES   = 4096;
  localparam int DEF_NUM_PAGES    = 64;
  localparam int DEF_HEADER_BYTES = 40;
  localparam int DEF_CHUNK_SLOTS  = 512;

  localparam int MIN_SIZE    = 14;
  localparam int MAX_SIZE    = 328;
  localparam int NUM_CLASSES = 158;

  localparam int PW  = 7;  // page index width, all ones is null
  localparam int CLW = 8;  // class index width

  localparam logic [PW-1:0] PAGE_NULL = '1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_PASS     = 2'd1,
    STATUS_NO_PAGES = 2'd2,
    STATUS_BAD_ADDR = 2'd3
  } status_t;

  typedef struct packed {
    logic        func;
    logic [15:0] size;
    logic [47:0] address;
  } req_t;

  typedef struct packed {
    logic [47:0] chunk_address;
    status_t     status;
    logic [6:0]  pages_in_use;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_A_HEAD,
    ST_A_SCAN,
    ST_A_CPP,
    ST_A_PAGE,
    ST_A_USE,
    ST_A_LINK,
    ST_A_DEC,
    ST_F_PDIV,
    ST_F_PAGE,
    ST_F_KDIV,
    ST_F_UPD,
    ST_F_PUSH_H,
    ST_F_PUSH_WR,
    ST_F_FULL,
    ST_U_START,
    ST_U_PREV,
    ST_U_NEXT,
    ST_U_NEXT_WR,
    ST_ADDR,
    ST_RESULT
  } state_t;

endpackage

>>> rtl/core/sscal_div.sv
// ----------------------------------------------------------------------------
// sscal_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sscal_div #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    dvs_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic [W:0]      trial;
  logic            fits;

  assign trial = {rem_q, quo_q[W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CNTW'(1);
      busy_q <= cnt_q != CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      quo_q <= dividend;
      dvs_q <= divisor;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= W'(trial - {1'b0, dvs_q});
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign busy      = busy_q;
  assign quotient  = quo_q;
  assign remainder = rem_q;

endmodule

>>> rtl/core/slab_size_class_allocator_core.sv
// allocate: a listed page is used directly; a fresh page needs the chunk-per-page divide,
//   and takes longer when the lowest-free-page scan (one page per cycle) outlasts the divide
// free: the chunk index comes from a bit-serial divide, DW = clog2(NUM_PAGES*PAGE_BYTES)+1 bits
//   (19 by default); page size is a power of two, so the page is split off by shift
// throughput: one request at a time; a new request is taken once the result is queued
// reset: synchronous, clears class heads, page map, page count and pool_base
// ----------------------------------------------------------------------------
// slab_size_class_allocator_core
// slab allocator over a page pool, with per-class page lists kept in memories
// ----------------------------------------------------------------------------
module slab_size_class_allocator_core import sscal_pkg::*; #(
  parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
  parameter int NUM_PAGES    = DEF_NUM_PAGES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int CHUNK_SLOTS  = DEF_CHUNK_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_data
);

  // chunk index / count width, all ones marks an empty freed stack
  localparam int KW   = $clog2(CHUNK_SLOTS) + 1;
  localparam int PIW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int LAW  = $clog2(NUM_PAGES * CHUNK_SLOTS);
  localparam int DW   = $clog2(NUM_PAGES * PAGE_BYTES) + 1;
  localparam int PBW  = $clog2(PAGE_BYTES);
  localparam int KSW  = KW + 9;
  localparam int NLNK = NUM_PAGES * CHUNK_SLOTS;
  localparam logic [47:0]   POOL_BYTES  = 48'(NUM_PAGES * PAGE_BYTES);
  localparam logic [DW-1:0] CARVE_BYTES = DW'(PAGE_BYTES - HEADER_BYTES);
  localparam logic [KW-1:0] CHUNK_NULL  = '1;

  // per-page bookkeeping, one word per page
  typedef struct packed {
    logic [PW-1:0]  nxt;
    logic [PW-1:0]  prv;
    logic [CLW-1:0] cls;
    logic [KW-1:0]  free_cnt;
    logic [KW-1:0]  total;
    logic [KW-1:0]  untouched;
    logic [KW-1:0]  freed;
  } page_t;

  state_t state_q, state_next;

  // control state
  logic [NUM_PAGES-1:0]   map_q;
  logic [PW-1:0]          count_q;
  logic [NUM_CLASSES-1:0] head_vld;
  logic [47:0]            base_q;

  // request context
  req_t          req_q;
  logic [PW-1:0] p_q;
  logic [PW-1:0] head_q;
  logic [PW-1:0] scan_q;
  logic [KW-1:0] k_q;
  page_t         ent_q;
  logic [DW-1:0] within_q;
  logic [KSW-1:0] ks_q;
  logic [47:0]   pofs_q;
  logic [47:0]   chunk_q;
  status_t       status_q;

  // memories
  logic [PW-1:0] head_mem [NUM_CLASSES];
  page_t         page_mem [NUM_PAGES];
  logic [KW-1:0] link_mem [NLNK];

  logic          head_re, head_we, head_rd_vld;
  logic [PW-1:0] head_wd, head_rd;
  logic          page_re, page_we;
  logic [PW-1:0] page_ra, page_wa;
  page_t         page_wd, page_rd;
  logic          link_re, link_we;
  logic [KW-1:0] link_k, link_wd, link_rd;
  logic [LAW-1:0] link_a;

  // divider
  logic          div_start, div_busy;
  logic [DW-1:0] div_a, div_b, div_quo, div_rem;

  // decode
  logic           in_range;
  logic [8:0]     size9, s_w;
  logic [CLW-1:0] c_w;
  logic [47:0]    off_w;
  logic [PW-1:0]  pidx_w;
  logic [PW-1:0]  head_w;
  logic [KW-1:0]  cpp_w;
  logic           kdiv_ok;
  logic           fpage_ok;
  logic           out_load;

  assign in_range = (req_q.size >= 16'(MIN_SIZE)) && (req_q.size <= 16'(MAX_SIZE));
  assign size9    = req_q.size[8:0];
  // round up to even
  assign s_w      = size9 + {8'd0, size9[0]};
  assign c_w      = CLW'((s_w - 9'(MIN_SIZE)) >> 1);
  // pool offset wraps at 48 bits
  assign off_w    = req_q.address - base_q;
  // page of the offset, only used once the offset is known to lie in the pool
  assign pidx_w   = PW'(off_w >> PBW);
  assign head_w   = head_rd_vld ? head_rd : PAGE_NULL;
  // chunks per page, capped at the slot count
  assign cpp_w    = (div_quo > DW'(CHUNK_SLOTS)) ? KW'(CHUNK_SLOTS) : div_quo[KW-1:0];
  assign kdiv_ok  = (div_rem == '0) && (div_quo < DW'(ent_q.untouched));
  assign fpage_ok = (page_rd.cls == c_w) && (within_q >= DW'(HEADER_BYTES));
  assign link_a   = LAW'(LAW'(p_q) * LAW'(CHUNK_SLOTS) + LAW'(link_k));
  assign out_load = (state_q == ST_RESULT) && (!out_valid || out_ready);

  assign in_ready  = state_q == ST_IDLE;
  assign cfg_ready = 1'b1;

  sscal_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // next state
  always_comb begin
    state_next = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (!in_range) state_next = ST_RESULT;
        else if (req_q.func == FUNC_ALLOC) state_next = ST_A_HEAD;
        else if (off_w < POOL_BYTES) state_next = ST_F_PDIV;
        else state_next = ST_RESULT;
      end
      ST_A_HEAD: state_next = (head_w == PAGE_NULL) ? ST_A_SCAN : ST_A_PAGE;
      ST_A_SCAN: begin
        priority if (scan_q == PW'(NUM_PAGES)) state_next = ST_RESULT;
        else if (!map_q[scan_q[PIW-1:0]]) state_next = ST_A_CPP;
        else state_next = ST_A_SCAN;
      end
      ST_A_CPP:  if (!div_busy) state_next = (cpp_w == '0) ? ST_RESULT : ST_A_USE;
      ST_A_PAGE: state_next = ST_A_USE;
      ST_A_USE:  state_next = (ent_q.freed != CHUNK_NULL) ? ST_A_LINK : ST_A_DEC;
      ST_A_LINK: state_next = ST_A_DEC;
      ST_A_DEC:  state_next = (ent_q.free_cnt == KW'(1)) ? ST_U_START : ST_ADDR;
      ST_F_PDIV: state_next = map_q[pidx_w[PIW-1:0]] ? ST_F_PAGE : ST_RESULT;
      ST_F_PAGE: state_next = fpage_ok ? ST_F_KDIV : ST_RESULT;
      ST_F_KDIV: if (!div_busy) state_next = kdiv_ok ? ST_F_UPD : ST_RESULT;
      ST_F_UPD:  state_next = (ent_q.free_cnt == KW'(1)) ? ST_F_PUSH_H : ST_F_FULL;
      ST_F_PUSH_H:  state_next = (head_w != PAGE_NULL) ? ST_F_PUSH_WR : ST_F_FULL;
      ST_F_PUSH_WR: state_next = ST_F_FULL;
      ST_F_FULL: state_next = (ent_q.free_cnt == ent_q.total) ? ST_U_START : ST_ADDR;
      ST_U_START:   state_next = (ent_q.prv == PAGE_NULL) ? ST_U_NEXT : ST_U_PREV;
      ST_U_PREV:    state_next = ST_U_NEXT;
      ST_U_NEXT:    state_next = (ent_q.nxt == PAGE_NULL) ? ST_ADDR : ST_U_NEXT_WR;
      ST_U_NEXT_WR: state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_RESULT;
      ST_RESULT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    head_re   = 1'b0;
    head_we   = 1'b0;
    head_wd   = p_q;
    page_re   = 1'b0;
    page_ra   = p_q;
    page_we   = 1'b0;
    page_wa   = p_q;
    page_wd   = ent_q;
    link_re   = 1'b0;
    link_we   = 1'b0;
    link_k    = ent_q.freed;
    link_wd   = ent_q.freed;
    div_start = 1'b0;
    div_a     = DW'(CARVE_BYTES);
    div_b     = DW'(s_w);
    unique case (state_q)
      ST_DECODE: begin
        if (in_range && req_q.func == FUNC_ALLOC) begin
          head_re = 1'b1;
        end
      end
      ST_A_HEAD: begin
        if (head_w == PAGE_NULL) begin
          div_start = 1'b1;
        end else begin
          page_re = 1'b1;
          page_ra = head_w;
        end
      end
      ST_A_CPP: if (!div_busy && cpp_w != '0) head_we = 1'b1;
      ST_A_USE: if (ent_q.freed != CHUNK_NULL) link_re = 1'b1;
      ST_A_DEC: begin
        page_we          = 1'b1;
        page_wd.free_cnt = ent_q.free_cnt - KW'(1);
      end
      ST_F_PDIV: begin
        if (map_q[pidx_w[PIW-1:0]]) begin
          page_re = 1'b1;
          page_ra = pidx_w;
        end
      end
      ST_F_PAGE: begin
        if (fpage_ok) begin
          div_start = 1'b1;
          div_a     = within_q - DW'(HEADER_BYTES);
        end
      end
      ST_F_KDIV: begin
        if (!div_busy && kdiv_ok) begin
          link_we = 1'b1;
          link_k  = div_quo[KW-1:0];
        end
      end
      ST_F_UPD: if (ent_q.free_cnt == KW'(1)) head_re = 1'b1;
      ST_F_PUSH_H: begin
        head_we = 1'b1;
        if (head_w != PAGE_NULL) begin
          page_re = 1'b1;
          page_ra = head_w;
        end
      end
      ST_F_PUSH_WR: begin
        page_we     = 1'b1;
        page_wa     = head_q;
        page_wd     = page_rd;
        page_wd.prv = p_q;
      end
      ST_F_FULL: page_we = 1'b1;
      ST_U_START: begin
        if (ent_q.prv == PAGE_NULL) begin
          head_we = 1'b1;
          head_wd = ent_q.nxt;
        end else begin
          page_re = 1'b1;
          page_ra = ent_q.prv;
        end
      end
      ST_U_PREV: begin
        page_we     = 1'b1;
        page_wa     = ent_q.prv;
        page_wd     = page_rd;
        page_wd.nxt = ent_q.nxt;
      end
      ST_U_NEXT: begin
        if (ent_q.nxt != PAGE_NULL) begin
          page_re = 1'b1;
          page_ra = ent_q.nxt;
        end
      end
      ST_U_NEXT_WR: begin
        page_we     = 1'b1;
        page_wa     = ent_q.nxt;
        page_wd     = page_rd;
        page_wd.prv = ent_q.prv;
      end
      default: ;
    endcase
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (head_we) head_mem[c_w] <= head_wd;
    if (head_re) begin
      head_rd     <= head_mem[c_w];
      head_rd_vld <= head_vld[c_w];
    end
  end

  always_ff @(posedge clk) begin
    if (page_we) page_mem[page_wa[PIW-1:0]] <= page_wd;
    if (page_re) page_rd <= page_mem[page_ra[PIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_a] <= link_wd;
    if (link_re) link_rd <= link_mem[link_a];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q   <= ST_IDLE;
      map_q     <= '0;
      count_q   <= '0;
      head_vld  <= '0;
      base_q    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_q <= state_next;
      if (cfg_valid) base_q <= cfg_data;
      // a class head counts as null until first written
      if (head_we) head_vld[c_w] <= 1'b1;
      if (state_q == ST_A_CPP && !div_busy && cpp_w != '0) begin
        map_q[p_q[PIW-1:0]] <= 1'b1;
        count_q             <= count_q + PW'(1);
      end
      if (state_q == ST_F_FULL && ent_q.free_cnt == ent_q.total) begin
        map_q[p_q[PIW-1:0]] <= 1'b0;
        count_q             <= count_q - PW'(1);
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    unique case (state_q)
      ST_IDLE: if (in_valid) req_q <= in_data;
      ST_DECODE: begin
        chunk_q <= '0;
        if (!in_range) status_q <= STATUS_PASS;
        else if (req_q.func == FUNC_FREE && off_w >= POOL_BYTES) status_q <= STATUS_BAD_ADDR;
        else status_q <= STATUS_OK;
      end
      ST_A_HEAD: begin
        head_q <= head_w;
        p_q    <= head_w;
        scan_q <= '0;
      end
      ST_A_SCAN: begin
        priority if (scan_q == PW'(NUM_PAGES)) status_q <= STATUS_NO_PAGES;
        else if (!map_q[scan_q[PIW-1:0]]) p_q <= scan_q;
        else scan_q <= scan_q + PW'(1);
      end
      ST_A_CPP: begin
        if (!div_busy) begin
          if (cpp_w == '0) begin
            status_q <= STATUS_NO_PAGES;
          end else begin
            ent_q.nxt       <= PAGE_NULL;
            ent_q.prv       <= PAGE_NULL;
            ent_q.cls       <= c_w;
            ent_q.free_cnt  <= cpp_w;
            ent_q.total     <= cpp_w;
            ent_q.untouched <= '0;
            ent_q.freed     <= CHUNK_NULL;
          end
        end
      end
      ST_A_PAGE: ent_q <= page_rd;
      ST_A_USE: begin
        if (ent_q.freed != CHUNK_NULL) begin
          k_q <= ent_q.freed;
        end else begin
          k_q             <= ent_q.untouched;
          ent_q.untouched <= ent_q.untouched + KW'(1);
        end
      end
      ST_A_LINK: ent_q.freed <= link_rd;
      ST_A_DEC: begin
        ent_q.free_cnt <= ent_q.free_cnt - KW'(1);
        ks_q           <= KSW'(k_q) * KSW'(s_w);
        pofs_q         <= 48'(p_q) * 48'(PAGE_BYTES);
      end
      ST_F_PDIV: begin
        p_q      <= pidx_w;
        within_q <= DW'(off_w[PBW-1:0]);
        if (!map_q[pidx_w[PIW-1:0]]) status_q <= STATUS_BAD_ADDR;
      end
      ST_F_PAGE: begin
        ent_q <= page_rd;
        if (!fpage_ok) status_q <= STATUS_BAD_ADDR;
      end
      ST_F_KDIV: begin
        if (!div_busy) begin
          if (!kdiv_ok) begin
            status_q <= STATUS_BAD_ADDR;
          end else begin
            ent_q.freed    <= div_quo[KW-1:0];
            ent_q.free_cnt <= ent_q.free_cnt + KW'(1);
          end
        end
      end
      ST_F_PUSH_H: begin
        head_q    <= head_w;
        ent_q.prv <= PAGE_NULL;
        ent_q.nxt <= head_w;
      end
      ST_ADDR: begin
        if (req_q.func == FUNC_ALLOC) begin
          chunk_q <= base_q + pofs_q + 48'(HEADER_BYTES) + 48'(ks_q);
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          out_data.chunk_address <= chunk_q;
          out_data.status        <= status_q;
          out_data.pages_in_use  <= count_q;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/sscal_checker.sv
// ----------------------------------------------------------------------------
// sscal_checker
// port-level checks for the slab size class allocator
// ----------------------------------------------------------------------------
module sscal_checker import sscal_pkg::*; #(
  parameter int NUM_PAGES = DEF_NUM_PAGES
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // only a good allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_OK |-> out_data.chunk_address == 48'd0)
    else $error("address on a failed request");

  // page count bounded by the pool
  a_pages_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pages_in_use <= 7'(NUM_PAGES))
    else $error("page count above pool size");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind slab_size_class_allocator_core sscal_checker #(.NUM_PAGES(NUM_PAGES)) u_sscal_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> bench/slab_size_class_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// slab_size_class_allocator_core_tb
// drives allocate and free requests into the slab allocator core, predicts
// each response with a behavioral copy of the allocator and compares fields
// ----------------------------------------------------------------------------
module slab_size_class_allocator_core_tb import sscal_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PG_BYTES  = DEF_PAGE_BYTES;
  localparam int PG_COUNT  = DEF_NUM_PAGES;
  localparam int HDR_BYTES = DEF_HEADER_BYTES;
  localparam int SLOTS     = DEF_CHUNK_SLOTS;
  localparam logic [9:0] CHUNK_NONE = 10'h3FF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [47:0] cfg_data;

  slab_size_class_allocator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // allocator shadow state
  logic [47:0] base_addr;
  logic [6:0]  class_head [NUM_CLASSES];
  logic [6:0]  pg_next [PG_COUNT];
  logic [6:0]  pg_prev [PG_COUNT];
  logic [7:0]  pg_class [PG_COUNT];
  int          pg_free [PG_COUNT];
  int          pg_total [PG_COUNT];
  int          pg_fresh [PG_COUNT];
  logic [9:0]  pg_stack [PG_COUNT];
  logic [9:0]  slot_link [PG_COUNT*SLOTS];
  bit          pg_used [PG_COUNT];
  int          used_pages;

  rsp_t expected_rsp [$];
  // chunks handed out, used to build well formed frees
  logic [47:0] live_addr [$];
  logic [15:0] live_size [$];

  int errors;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  task automatic shadow_reset();
    base_addr = '0;
    used_pages = 0;
    foreach (class_head[i]) class_head[i] = PAGE_NULL;
    foreach (pg_used[i]) pg_used[i] = 1'b0;
  endtask

  function automatic void page_push(int c, int p);
    logic [6:0] h;
    h = class_head[c];
    pg_prev[p] = PAGE_NULL;
    pg_next[p] = h;
    if (h != PAGE_NULL) pg_prev[h] = p[6:0];
    class_head[c] = p[6:0];
  endfunction

  function automatic void page_unlink(int c, int p);
    logic [6:0] pr, nx;
    pr = pg_prev[p];
    nx = pg_next[p];
    if (pr == PAGE_NULL) class_head[c] = nx;
    else pg_next[pr] = nx;
    if (nx != PAGE_NULL) pg_prev[nx] = pr;
  endfunction

  function automatic rsp_t allocator_predict(req_t rq);
    rsp_t r;
    int s, c, p, k, total;
    logic [47:0] off;
    int pg_ofs;
    r = '0;
    r.status = STATUS_OK;
    if (rq.size < MIN_SIZE || rq.size > MAX_SIZE) begin
      r.status = STATUS_PASS;
    end else begin
      s = (int'(rq.size) + 1) & ~1;
      c = (s - MIN_SIZE) / 2;
      if (rq.func == FUNC_ALLOC) begin
        p = class_head[c];
        if (p == PAGE_NULL) begin
          total = (PG_BYTES - HDR_BYTES) / s;
          if (total > SLOTS) total = SLOTS;
          p = -1;
          for (int i = 0; i < PG_COUNT; i++)
            if (!pg_used[i] && p < 0) p = i;
          if (p < 0 || total == 0) r.status = STATUS_NO_PAGES;
          else begin
            pg_used[p] = 1'b1;
            used_pages++;
            pg_class[p] = c[7:0];
            pg_total[p] = total;
            pg_free[p] = total;
            pg_fresh[p] = 0;
            pg_stack[p] = CHUNK_NONE;
            page_push(c, p);
          end
        end
        if (r.status == STATUS_OK) begin
          if (pg_stack[p] != CHUNK_NONE) begin
            k = pg_stack[p];
            pg_stack[p] = slot_link[p*SLOTS + k];
          end else begin
            k = pg_fresh[p];
            pg_fresh[p] = k + 1;
          end
          pg_free[p]--;
          if (pg_free[p] == 0) page_unlink(c, p);
          r.chunk_address = base_addr + 48'(p) * PG_BYTES + HDR_BYTES + 48'(k) * s;
        end
      end else begin
        off = rq.address - base_addr;
        if (off / PG_BYTES >= PG_COUNT) r.status = STATUS_BAD_ADDR;
        else begin
          p = int'(off / PG_BYTES);
          pg_ofs = int'(off % PG_BYTES);
          if (!pg_used[p] || pg_class[p] != c || pg_ofs < HDR_BYTES
              || (pg_ofs - HDR_BYTES) % s != 0
              || (pg_ofs - HDR_BYTES) / s >= pg_fresh[p])
            r.status = STATUS_BAD_ADDR;
          else begin
            k = (pg_ofs - HDR_BYTES) / s;
            slot_link[p*SLOTS + k] = pg_stack[p];
            pg_stack[p] = k[9:0];
            pg_free[p]++;
            if (pg_free[p] == 1) page_push(c, p);
            if (pg_free[p] == pg_total[p]) begin
              page_unlink(c, p);
              pg_used[p] = 1'b0;
              used_pages--;
            end
          end
        end
      end
    end
    r.pages_in_use = used_pages[6:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------
  task automatic send_request(logic f, logic [15:0] sz, logic [47:0] addr);
    req_t rq;
    rsp_t r;
    rq.func = f;
    rq.size = sz;
    rq.address = addr;
    // pause between requests, so valid drops before it rises again
    do @(posedge clk); while ($urandom_range(99) < idle_pct);
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    r = allocator_predict(rq);
    expected_rsp.push_back(r);
    if (f == FUNC_ALLOC && r.status == STATUS_OK) begin
      live_addr.push_back(r.chunk_address);
      live_size.push_back(sz);
    end
  endtask

  task automatic wait_drained();
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_base(logic [47:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // new base invalidates addresses we remember
    base_addr = v;
    live_addr.delete();
    live_size.delete();
  endtask

  // free a remembered chunk, picked at random
  task automatic free_live();
    int j;
    j = $urandom_range(live_addr.size() - 1);
    send_request(FUNC_FREE, live_size[j], live_addr[j]);
    live_addr.delete(j);
    live_size.delete(j);
  endtask

  // ---------------------------------------------------------------------------
  // response checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %h", out_data);
      end else begin
        rsp_t e;
        e = expected_rsp.pop_front();
        if (e.chunk_address !== out_data.chunk_address || e.status !== out_data.status
            || e.pages_in_use !== out_data.pages_in_use) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp addr %h st %0d pages %0d, got addr %h st %0d pages %0d",
                     e.chunk_address, e.status, e.pages_in_use,
                     out_data.chunk_address, out_data.status, out_data.pages_in_use);
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog, counts cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // passthrough edges and odd size rounding
    send_request(FUNC_ALLOC, 16'd0, '0);
    send_request(FUNC_ALLOC, 16'd13, '0);
    send_request(FUNC_ALLOC, 16'd329, '1);
    send_request(FUNC_FREE, 16'hFFFF, '1);
    send_request(FUNC_ALLOC, 16'd14, '1);
    send_request(FUNC_ALLOC, 16'd15, '0);
    send_request(FUNC_ALLOC, 16'd328, '0);
    send_request(FUNC_ALLOC, 16'd327, '0);
    // bad frees: outside pool, header, misaligned, wrong class, never handed out
    send_request(FUNC_FREE, 16'd14, 48'hFFFF_FFFF_FFF0);
    send_request(FUNC_FREE, 16'd14, base_addr + 8);
    send_request(FUNC_FREE, 16'd14, base_addr + HDR_BYTES + 1);
    send_request(FUNC_FREE, 16'd20, base_addr + HDR_BYTES);
    send_request(FUNC_FREE, 16'd14, base_addr + HDR_BYTES + 14*40);
    send_request(FUNC_FREE, 16'd200, base_addr + 63*PG_BYTES + HDR_BYTES);
    // two frees of a slot not yet handed out, an allocate, then good frees
    send_request(FUNC_FREE, 16'd14, base_addr + HDR_BYTES + 14);
    send_request(FUNC_FREE, 16'd14, base_addr + HDR_BYTES + 14);
    send_request(FUNC_ALLOC, 16'd14, '0);
    send_request(FUNC_FREE, 16'd328, base_addr + 2*PG_BYTES + HDR_BYTES);
    send_request(FUNC_FREE, 16'd328, base_addr + 2*PG_BYTES + HDR_BYTES + 328);
  endtask

  // fill the whole pool so the out of pages path is hit, then release it
  task automatic test_exhaust();
    for (int i = 0; i < PG_COUNT + 3; i++)
      send_request(FUNC_ALLOC, 16'(MIN_SIZE + 2*(i % NUM_CLASSES)), '0);
    while (live_addr.size() != 0) free_live();
  endtask

  task automatic test_random(int n);
    int m;
    logic [15:0] sz;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(99);
      // keep to a few classes so pages fill and drain
      sz = 16'($urandom_range(3) * 60 + MIN_SIZE + $urandom_range(1));
      if (m < 45) send_request(FUNC_ALLOC, sz, 48'({$urandom, $urandom}));
      else if (m < 85 && live_addr.size() != 0) free_live();
      else if (m < 92) send_request(1'($urandom_range(1)), 16'($urandom),
                                    48'({$urandom, $urandom}));
      else send_request(FUNC_FREE, 16'($urandom_range(MAX_SIZE, MIN_SIZE)),
                        base_addr + 48'($urandom_range(PG_COUNT*PG_BYTES + 99)));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    shadow_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_exhaust();
    wait_drained();
    write_pool_base(48'hFFFF_FFFF_F000);   // pool wraps past the top
    test_directed();
    test_random(60);
    wait_drained();
    write_pool_base(48'h0000_1234_5678);   // not page aligned
    idle_pct = 85;
    test_random(60);
    wait_drained();                        // sender pauses until all is back
    write_pool_base(48'hFFFF_FFFF_FFFF);
    idle_pct = 0;
    stall_pct = 85;
    test_random(60);
    wait_drained();
    write_pool_base(48'h0);
    idle_pct = 18;
    stall_pct = 18;
    test_random(120);
    idle_pct = 0;
    stall_pct = 0;
    test_random(30);
    wait_drained();

    if (errors == 0 && expected_rsp.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
